/* hdl/lzbd_pkg.sv */
// Shared constants and types for the block decompressor.
package lzbd_pkg;

  localparam int unsigned HistoryBytesDefault = 8192;
  localparam int unsigned WordsPerItemDefault = 8;
  localparam logic [13:0] LimitReset = 14'd4160;

  // parse phases
  localparam logic [2:0] PH_FIRST  = 3'd0;
  localparam logic [2:0] PH_CTRL   = 3'd1;
  localparam logic [2:0] PH_LIT    = 3'd2;
  localparam logic [2:0] PH_LEN    = 3'd3;
  localparam logic [2:0] PH_DIST   = 3'd4;
  localparam logic [2:0] PH_FAR_HI = 3'd5;
  localparam logic [2:0] PH_FAR_LO = 3'd6;
  localparam logic [2:0] PH_COPY   = 3'd7;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_BAD_REF  = 3'd2;
  localparam logic [2:0] ST_LIT_TRUNC = 3'd3;
  localparam logic [2:0] ST_HDR_TRUNC = 3'd4;
  localparam logic [2:0] ST_NOT_READY = 3'd5;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_CONT = 1'b1;

  localparam logic [4:0] HighOffsetFar = 5'd31;
  localparam logic [7:0] ByteAllOnes = 8'd255;
  localparam logic [13:0] LengthSat = 14'd16383;
  localparam logic [16:0] FarBias = 17'd8192;
  localparam logic [2:0] LenExtCode = 3'd6;

  // one result transaction
  typedef struct packed {
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic [2:0]  status;
    logic        block_done;
    logic [13:0] block_length;
    logic        last_of_item;
  } result_t;

endpackage

/* hdl/lz_block_decompressor_core.sv */
// FastLZ level 1/2 block decompressor: parser, copy engine and result buffer.
//
// Usage: one compressed byte per input transaction (opcode 0); when a match
// copy is longer than one item's share (8*WORDS_PER_ITEM bytes) the sender
// issues continue transactions (opcode 1) until the copy completes. Each
// input transaction produces 1 to WORDS_PER_ITEM result transactions of up to
// eight bytes each; last_of_item marks the final one, block_done and
// block_length mark the end of a block.
// A header or literal byte gives its result from the result register in the
// cycle after accept. A match copy moves each byte through the history memory
// in S_RD (read issue) then S_WR (registered read data written back), and
// hands over each 8-byte result in S_EMIT, which waits while an earlier result
// is still held. A block end passes through S_WAIT to clear block state. Items
// are processed one at a time; the next item is taken once the previous item's
// results have all been handed over. A result that waits under stall holds
// its payload.
// Reset: all block state clears, output_limit returns to 4160. History
// contents are not cleared; only bytes written in the current block are read.
module lz_block_decompressor_core import lzbd_pkg::*; #(
  parameter int unsigned HISTORY_BYTES  = HistoryBytesDefault,
  parameter int unsigned WORDS_PER_ITEM = WordsPerItemDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [7:0]  data_byte,
  input  logic        end_of_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic [2:0]  status,
  output logic        block_done,
  output logic [13:0] block_length,
  output logic        last_of_item
);

  localparam int unsigned AW = $clog2(HISTORY_BYTES);
  localparam int unsigned CapBytes = 8 * WORDS_PER_ITEM;
  localparam logic [13:0] Cap14 = 14'(CapBytes);
  localparam logic [14:0] HistCap = 15'(HISTORY_BYTES > 16384 ? 16384 : HISTORY_BYTES);

  // controller states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_WR    = 3'd2;
  localparam logic [2:0] S_EMIT  = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0]  state;
  logic [13:0] output_limit;

  // block state
  logic [13:0] bytes_written;
  logic [2:0]  parse_phase;
  logic        level_two;
  logic [5:0]  literal_left;
  logic [13:0] match_length;
  logic [4:0]  high_offset;
  logic [16:0] match_distance;
  logic [13:0] copy_left;
  logic [2:0]  error_code;
  logic        end_pending;

  // copy progress within an item
  logic [6:0]  copied;      // bytes copied in this item
  logic [6:0]  copy_n;      // bytes to copy in this item
  logic [63:0] word;        // current 8-byte result being assembled
  logic [3:0]  word_cnt;

  // result register
  result_t res;
  logic    res_valid;

  // memory port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  lzbd_history #(.HISTORY_BYTES(HISTORY_BYTES)) u_hist (
    .clk(clk), .wr_en(mem_we), .wr_addr(mem_waddr), .wr_data(mem_wdata),
    .rd_addr(mem_raddr), .rd_data(mem_rdata)
  );

  assign in_stall = (state != S_IDLE) || res_valid;
  logic in_acc;
  assign in_acc = in_valid && !in_stall;
  logic out_acc;
  assign out_acc = res_valid && !out_stall;

  assign out_valid    = res_valid;
  assign out_bytes    = res.out_bytes;
  assign byte_count   = res.byte_count;
  assign status       = res.status;
  assign block_done   = res.block_done;
  assign block_length = res.block_length;
  assign last_of_item = res.last_of_item;

  // effective limit
  logic [14:0] eff_limit;
  assign eff_limit = ({1'b0, output_limit} > HistCap) ? HistCap : {1'b0, output_limit};

  // source address for the next copied byte
  logic [16:0] src_full;
  assign src_full = 17'(bytes_written) - match_distance;
  assign mem_raddr = AW'(src_full);

  // byte write on literal and copy paths
  assign mem_we    = (state == S_WR) || (in_acc && opcode == OP_BYTE &&
                     error_code == ST_OK && parse_phase == PH_LIT);
  assign mem_waddr = AW'(bytes_written);
  assign mem_wdata = (state == S_WR) ? mem_rdata : data_byte;

  // combinational parse of an accepted byte
  logic [14:0] run_total, match_total;
  logic [16:0] dist_new;
  logic [14:0] len_sum;
  always_comb begin
    run_total   = 15'(bytes_written) + 15'(parse_phase == PH_FIRST ?
                  {1'b0, data_byte[4:0]} : data_byte[5:0]) + 15'd1;
    match_total = 15'(bytes_written) + 15'(match_length) + 15'd3;
    dist_new    = (parse_phase == PH_DIST) ?
                  17'({high_offset, data_byte}) + 17'd1 :
                  match_distance + 17'(data_byte) + FarBias;
    len_sum     = 15'(match_length) + 15'(data_byte);
  end

  // controller: parser, copy engine and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; output_limit <= LimitReset; res_valid <= 1'b0;
      bytes_written <= '0; parse_phase <= PH_FIRST; level_two <= 1'b0;
      literal_left <= '0; match_length <= '0; high_offset <= '0;
      match_distance <= '0; copy_left <= '0; error_code <= ST_OK;
      end_pending <= 1'b0; copied <= '0; copy_n <= '0; word <= '0;
      word_cnt <= '0;
    end else begin
      if (cfg_we) output_limit <= cfg_wdata;
      if (out_acc) res_valid <= 1'b0;

      unique case (state)
        S_IDLE: if (in_acc) begin
          // default result: no bytes, last of item
          res <= '{out_bytes: '0, byte_count: '0, status: ST_OK, block_done: 1'b0,
                   block_length: '0, last_of_item: 1'b1};
          res_valid <= 1'b1;
          if (parse_phase == PH_COPY || opcode == OP_CONT) begin
            if (parse_phase == PH_COPY && opcode == OP_CONT) begin
              res_valid <= 1'b0;
              copy_n <= 7'(copy_left < Cap14 ? copy_left : Cap14);
              copied <= '0; word <= '0; word_cnt <= '0;
              state <= S_RD;
            end else begin
              res.status <= ST_NOT_READY;
            end
          end else if (error_code != ST_OK) begin
            res.status <= error_code;
            if (end_of_block) begin
              res.block_done <= 1'b1; res.block_length <= bytes_written;
              state <= S_WAIT;
            end
          end else begin
            priority if (parse_phase == PH_FIRST ||
                         (parse_phase == PH_CTRL && data_byte < 8'd32)) begin
              if (parse_phase == PH_FIRST) level_two <= (data_byte[7:5] != 3'd0);
              if (run_total > eff_limit) begin
                error_code <= ST_OVERFLOW; res.status <= ST_OVERFLOW;
                if (end_of_block) begin
                  res.block_done <= 1'b1; res.block_length <= bytes_written;
                  state <= S_WAIT;
                end
              end else begin
                literal_left <= 6'(run_total - 15'(bytes_written));
                parse_phase <= PH_LIT;
                if (end_of_block) begin
                  res.status <= ST_LIT_TRUNC; res.block_done <= 1'b1;
                  res.block_length <= bytes_written; state <= S_WAIT;
                end
              end
            end else if (parse_phase == PH_CTRL) begin
              match_length <= 14'(data_byte[7:5] - 3'd1);
              high_offset <= data_byte[4:0];
              parse_phase <= (data_byte[7:5] - 3'd1 == LenExtCode) ? PH_LEN : PH_DIST;
              if (end_of_block) begin
                error_code <= ST_HDR_TRUNC; res.status <= ST_HDR_TRUNC;
                res.block_done <= 1'b1; res.block_length <= bytes_written;
                state <= S_WAIT;
              end
            end else if (parse_phase == PH_LIT) begin
              bytes_written <= bytes_written + 14'd1;
              literal_left <= literal_left - 6'd1;
              res.out_bytes <= 64'(data_byte); res.byte_count <= 4'd1;
              if (literal_left == 6'd1) begin
                parse_phase <= PH_CTRL;
                if (end_of_block) begin
                  res.block_done <= 1'b1; res.block_length <= bytes_written + 14'd1;
                  state <= S_WAIT;
                end
              end else if (end_of_block) begin
                res.status <= ST_LIT_TRUNC; res.block_done <= 1'b1;
                res.block_length <= bytes_written + 14'd1; state <= S_WAIT;
              end
            end else if (parse_phase == PH_LEN) begin
              match_length <= (len_sum > 15'(LengthSat)) ? LengthSat : 14'(len_sum);
              if (!(level_two && data_byte == ByteAllOnes)) parse_phase <= PH_DIST;
              if (end_of_block) begin
                error_code <= ST_HDR_TRUNC; res.status <= ST_HDR_TRUNC;
                res.block_done <= 1'b1; res.block_length <= bytes_written;
                state <= S_WAIT;
              end
            end else if (parse_phase == PH_FAR_HI) begin
              match_distance <= {1'b0, data_byte, 8'd0};
              parse_phase <= PH_FAR_LO;
              if (end_of_block) begin
                error_code <= ST_HDR_TRUNC; res.status <= ST_HDR_TRUNC;
                res.block_done <= 1'b1; res.block_length <= bytes_written;
                state <= S_WAIT;
              end
            end else if (parse_phase == PH_DIST && level_two &&
                         data_byte == ByteAllOnes && high_offset == HighOffsetFar) begin
              parse_phase <= PH_FAR_HI;
              if (end_of_block) begin
                error_code <= ST_HDR_TRUNC; res.status <= ST_HDR_TRUNC;
                res.block_done <= 1'b1; res.block_length <= bytes_written;
                state <= S_WAIT;
              end
            end else begin
              // match start (near or far distance)
              match_distance <= dist_new;
              if (match_total > eff_limit || dist_new > 17'(bytes_written)) begin
                error_code <= (match_total > eff_limit) ? ST_OVERFLOW : ST_BAD_REF;
                res.status <= (match_total > eff_limit) ? ST_OVERFLOW : ST_BAD_REF;
                if (end_of_block) begin
                  res.block_done <= 1'b1; res.block_length <= bytes_written;
                  state <= S_WAIT;
                end
              end else begin
                res_valid <= 1'b0;
                copy_left <= match_length + 14'd3;
                end_pending <= end_of_block;
                parse_phase <= PH_COPY;
                copy_n <= 7'((match_length + 14'd3) < Cap14 ?
                             (match_length + 14'd3) : Cap14);
                copied <= '0; word <= '0; word_cnt <= '0;
                state <= S_RD;
              end
            end
          end
        end
        // read issued combinationally from mem_raddr; data next cycle
        S_RD: state <= S_WR;
        S_WR: begin
          bytes_written <= bytes_written + 14'd1;
          copy_left <= copy_left - 14'd1;
          copied <= copied + 7'd1;
          word[8*word_cnt[2:0] +: 8] <= mem_rdata;
          word_cnt <= word_cnt + 4'd1;
          if (word_cnt == 4'd7 || copied + 7'd1 == copy_n) state <= S_EMIT;
          else state <= S_RD;
        end
        S_EMIT: if (!res_valid) begin
          res.out_bytes <= word; res.byte_count <= word_cnt;
          res.status <= ST_OK;
          res.last_of_item <= (copied == copy_n);
          res.block_done <= 1'b0; res.block_length <= '0;
          res_valid <= 1'b1;
          word <= '0; word_cnt <= '0;
          if (copied == copy_n) begin
            state <= S_IDLE;
            if (copy_left == 14'd0) begin
              parse_phase <= PH_CTRL; end_pending <= 1'b0;
              if (end_pending) begin
                res.block_done <= 1'b1; res.block_length <= bytes_written;
                state <= S_WAIT;
              end
            end
          end else begin
            state <= S_RD;
          end
        end
        S_WAIT: begin
          // block ended: clear block state
          bytes_written <= '0; parse_phase <= PH_FIRST; level_two <= 1'b0;
          literal_left <= '0; match_length <= '0; high_offset <= '0;
          match_distance <= '0; copy_left <= '0; error_code <= ST_OK;
          end_pending <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // no input taken while a copy is in flight
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD || state == S_WR) |-> in_stall) else $error("accept while busy");
  // a stalled result keeps its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_stall) |=> (res_valid && $stable(res))) else $error("result changed");
  // byte count never exceeds one word
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.byte_count <= 4'd8)) else $error("bad byte count");
  // copy read state always has bytes left
  a_copy: assert property (@(posedge clk) disable iff (rst)
    (state == S_RD) |-> (copy_left != 14'd0)) else $error("copy underflow");
`endif

endmodule

/* hdl/lzbd_history.sv */
// Byte-wide history memory, one write and one read port, registered read.
module lzbd_history import lzbd_pkg::*; #(
  parameter int unsigned HISTORY_BYTES = HistoryBytesDefault
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(HISTORY_BYTES)-1:0] wr_addr,
  input  logic [7:0]                       wr_data,
  input  logic [$clog2(HISTORY_BYTES)-1:0] rd_addr,
  output logic [7:0]                       rd_data
);

  logic [7:0] mem [HISTORY_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
